>>> sv/evft_pkg.sv
// ----------------------------------------------------------------------------
// Envelope follower and trigger package
// Register indexes, reset values and fixed constants shared by the block.
// ----------------------------------------------------------------------------
package evft_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TRACK_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POST_FADER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SCALE   = 3'd4;

  localparam logic [15:0] ATTACK_COEF_RST = 16'd62000;
  localparam logic [15:0] DECAY_COEF_RST  = 16'd65000;
  localparam logic [15:0] OUT_SCALE_RST   = 16'd256;

  localparam logic [23:0] TRIG_THRESHOLD = 24'd1000000;
  localparam logic [5:0]  HOLD_STEPS     = 6'd40;
  localparam logic [5:0]  LOW_STEPS      = 6'd40;
  localparam logic [5:0]  LOW_MAX        = 6'd63;
  localparam logic [15:0] MIN_TRIG_Q15   = 16'd66;
  localparam logic [15:0] HALF_Q15       = 16'd16384;
  localparam logic [15:0] ONE_Q15        = 16'd32768;

  typedef logic [15:0] q15_t;

endpackage

>>> sv/envelope_follower_trigger.sv
// ----------------------------------------------------------------------------
// Envelope follower and trigger
// Per-channel attack/decay envelope follower with a gate mode, built around
// one bit-serial shift-add multiplier.
// ----------------------------------------------------------------------------
// Each request carries one channel's level and gain and returns one result.
// All products go through a single shift-add multiplier that consumes one
// multiplier bit per cycle. A request in follow mode forms the envelope
// product and then the output-scale product (post mode adds the gain product
// between them); trigger mode forms one product and a request for a channel
// that does not exist goes straight to the final step. A new request is taken
// while the previous result still waits on the output register; a held
// output only delays the final step of the following request.
module envelope_follower_trigger
  import evft_pkg::*;
#(
  parameter int CHANNELS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_channel,
  input  logic [23:0]          in_level_in,
  input  logic [15:0]          in_channel_gain,
  input  logic [15:0]          in_trigger_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_channel_out,
  output logic [15:0]          out_env_out
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENV   = 3'd1;
  localparam logic [2:0] S_GAIN  = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_ATT   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic        track_mode_r;
  logic        post_fader_r;
  logic [15:0] attack_coef_r;
  logic [15:0] decay_coef_r;
  logic [15:0] out_scale_r;

  logic [31:0] env_mem_r  [CHANNELS];
  logic [5:0]  hold_mem_r [CHANNELS];
  logic [5:0]  low_mem_r  [CHANNELS];
  q15_t        last_mem_r [CHANNELS];

  logic [2:0]      state_r, state_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [2:0]      ch_r, ch_nxt;
  logic [CH_W-1:0] idx_r, idx_nxt;
  logic            ok_r, ok_nxt;
  logic [15:0]     gain_r, gain_nxt;
  logic [32:0]     hi_r, hi_nxt;
  logic [15:0]     lo_r, lo_nxt;
  logic [32:0]     m_r, m_nxt;
  logic [32:0]     y_r, y_nxt;
  q15_t            res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      out_channel_r, out_channel_nxt;
  q15_t            out_env_r, out_env_nxt;

  logic [CH_W-1:0] in_idx;
  logic            in_ok;
  logic [31:0]     env_q;
  logic [31:0]     target;
  logic [33:0]     p_sum;
  logic            mul_last;
  logic [39:0]     p_scaled;
  logic [5:0]      hold_q;
  logic [5:0]      low_q;
  logic [5:0]      low_inc;
  q15_t            last_q;

  logic            env_we;
  logic [31:0]     env_wdata;
  logic            cnt_we;
  logic [5:0]      hold_wdata;
  logic [5:0]      low_wdata;
  logic            last_we;

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_channel_out = out_channel_r;
  assign out_env_out     = out_env_r;

  assign in_idx   = CH_W'(in_channel);
  assign in_ok    = (32'(in_channel) < CHANNELS);
  assign env_q    = env_mem_r[in_idx];
  assign target   = {in_level_in, 8'd0};
  assign p_sum    = {1'b0, hi_r} + (lo_r[0] ? {1'b0, m_r} : {1'b0, y_r});
  assign mul_last = (cnt_r == 4'd15);
  assign p_scaled = {p_sum, lo_r[15:10]};
  assign hold_q   = hold_mem_r[idx_r];
  assign low_q    = low_mem_r[idx_r];
  assign last_q   = last_mem_r[idx_r];
  assign low_inc  = (low_q < LOW_MAX) ? (low_q + 6'd1) : low_q;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    ch_nxt          = ch_r;
    idx_nxt         = idx_r;
    ok_nxt          = ok_r;
    gain_nxt        = gain_r;
    hi_nxt          = hi_r;
    lo_nxt          = lo_r;
    m_nxt           = m_r;
    y_nxt           = y_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r;
    out_channel_nxt = out_channel_r;
    out_env_nxt     = out_env_r;
    env_we          = 1'b0;
    env_wdata       = p_sum[32:1];
    cnt_we          = 1'b0;
    hold_wdata      = hold_q;
    low_wdata       = low_q;
    last_we         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (state_r == S_ENV || state_r == S_GAIN || state_r == S_SCALE || state_r == S_ATT) begin
      hi_nxt  = p_sum[33:1];
      lo_nxt  = {p_sum[0], lo_r[15:1]};
      cnt_nxt = cnt_r + 4'd1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt   = in_channel;
          idx_nxt  = in_idx;
          ok_nxt   = in_ok;
          gain_nxt = in_channel_gain;
          cnt_nxt  = 4'd0;
          if (!in_ok) begin
            res_nxt   = '0;
            state_nxt = S_FIN;
          end else if (!track_mode_r) begin
            hi_nxt    = {1'b0, target};
            m_nxt     = {1'b0, env_q};
            y_nxt     = {1'b0, target};
            lo_nxt    = (env_q < target) ? attack_coef_r : decay_coef_r;
            state_nxt = S_ENV;
          end else begin
            hi_nxt = '0;
            m_nxt  = {9'd0, in_level_in};
            y_nxt  = '0;
            if (post_fader_r) begin
              lo_nxt = in_channel_gain;
            end else if (in_trigger_level < MIN_TRIG_Q15) begin
              lo_nxt = HALF_Q15;
            end else begin
              lo_nxt = in_trigger_level;
            end
            state_nxt = S_ATT;
          end
        end
      end
      S_ENV: begin
        if (mul_last) begin
          env_we  = 1'b1;
          hi_nxt  = '0;
          y_nxt   = '0;
          cnt_nxt = 4'd0;
          m_nxt   = {1'b0, p_sum[32:1]};
          if (post_fader_r) begin
            lo_nxt    = gain_r;
            state_nxt = S_GAIN;
          end else begin
            lo_nxt    = out_scale_r;
            state_nxt = S_SCALE;
          end
        end
      end
      S_GAIN: begin
        if (mul_last) begin
          hi_nxt    = '0;
          cnt_nxt   = 4'd0;
          m_nxt     = p_sum[32:0];
          lo_nxt    = out_scale_r;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (mul_last) begin
          res_nxt   = (p_scaled > {24'd0, ONE_Q15}) ? ONE_Q15 : p_scaled[15:0];
          state_nxt = S_FIN;
        end
      end
      S_ATT: begin
        if (mul_last) begin
          cnt_we = 1'b1;
          if (hold_q != 6'd0) begin
            hold_wdata = hold_q - 6'd1;
            res_nxt    = last_q;
          end else if (p_sum > {10'd0, TRIG_THRESHOLD}) begin
            low_wdata  = '0;
            hold_wdata = HOLD_STEPS;
            res_nxt    = ONE_Q15;
          end else begin
            low_wdata = low_inc;
            res_nxt   = (low_inc >= LOW_STEPS) ? q15_t'(0) : last_q;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_channel_nxt = ch_r;
          out_env_nxt     = res_r;
          last_we         = ok_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      track_mode_r  <= 1'b0;
      post_fader_r  <= 1'b0;
      attack_coef_r <= ATTACK_COEF_RST;
      decay_coef_r  <= DECAY_COEF_RST;
      out_scale_r   <= OUT_SCALE_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_TRACK_MODE:  track_mode_r  <= cfg_wdata[0];
          REG_POST_FADER:  post_fader_r  <= cfg_wdata[0];
          REG_ATTACK_COEF: attack_coef_r <= cfg_wdata;
          REG_DECAY_COEF:  decay_coef_r  <= cfg_wdata;
          REG_OUT_SCALE:   out_scale_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r          <= ch_nxt;
    idx_r         <= idx_nxt;
    ok_r          <= ok_nxt;
    gain_r        <= gain_nxt;
    hi_r          <= hi_nxt;
    lo_r          <= lo_nxt;
    m_r           <= m_nxt;
    y_r           <= y_nxt;
    res_r         <= res_nxt;
    out_channel_r <= out_channel_nxt;
    out_env_r     <= out_env_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        env_mem_r[i]  <= '0;
        hold_mem_r[i] <= '0;
        low_mem_r[i]  <= '0;
        last_mem_r[i] <= '0;
      end
    end else begin
      if (env_we) begin
        env_mem_r[idx_r] <= env_wdata;
      end
      if (cnt_we) begin
        hold_mem_r[idx_r] <= hold_wdata;
        low_mem_r[idx_r]  <= low_wdata;
      end
      if (last_we) begin
        last_mem_r[idx_r] <= res_r;
      end
    end
  end

endmodule
